@@ rtl/fenwick_range_add_point_query_assert.svh @@
// Assertion macros used by the RTL of the range-add point-query tree.
`ifndef FENWICK_RANGE_ADD_POINT_QUERY_ASSERT_SVH
`define FENWICK_RANGE_ADD_POINT_QUERY_ASSERT_SVH
`ifndef SYNTHESIS
`define FRAPQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FRAPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FRAPQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define FRAPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/frapq_pkg.sv @@
`default_nettype none
package frapq_pkg;

  localparam int POS_W  = 11;
  localparam int VAL_W  = 64;
  localparam int WALK_W = 12;
  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] S_CLR    = 4'd0;
  localparam logic [STEP_W-1:0] S_IDLE   = 4'd1;
  localparam logic [STEP_W-1:0] S_LOAD   = 4'd2;
  localparam logic [STEP_W-1:0] S_A1RD   = 4'd3;
  localparam logic [STEP_W-1:0] S_A1WR   = 4'd4;
  localparam logic [STEP_W-1:0] S_A2INIT = 4'd5;
  localparam logic [STEP_W-1:0] S_A2RD   = 4'd6;
  localparam logic [STEP_W-1:0] S_A2WR   = 4'd7;
  localparam logic [STEP_W-1:0] S_QCLAMP = 4'd8;
  localparam logic [STEP_W-1:0] S_QRD    = 4'd9;
  localparam logic [STEP_W-1:0] S_QACC   = 4'd10;
  localparam logic [STEP_W-1:0] S_QOUT   = 4'd11;

  localparam logic [2:0] C_NEVER     = 3'd0;
  localparam logic [2:0] C_ALWAYS    = 3'd1;
  localparam logic [2:0] C_ACCEPT    = 3'd2;
  localparam logic [2:0] C_CLR_DONE  = 3'd3;
  localparam logic [2:0] C_QUERY     = 3'd4;
  localparam logic [2:0] C_WALK_DONE = 3'd5;
  localparam logic [2:0] C_POS_ZERO  = 3'd6;
  localparam logic [2:0] C_OUT_FREE  = 3'd7;

  localparam logic [2:0] P_HOLD  = 3'd0;
  localparam logic [2:0] P_START = 3'd1;
  localparam logic [2:0] P_END1  = 3'd2;
  localparam logic [2:0] P_CLAMP = 3'd3;
  localparam logic [2:0] P_UP    = 3'd4;
  localparam logic [2:0] P_DOWN  = 3'd5;

  typedef struct packed {
    logic              in_ready;
    logic              mem_rd;
    logic              mem_wr;
    logic              wr_zero;
    logic [2:0]        pos_op;
    logic              neg_delta;
    logic              sum_clr;
    logic              sum_acc;
    logic              out_set;
    logic [2:0]        cond;
    logic              stay;
    logic [STEP_W-1:0] target;
  } ctl_t;

  function automatic ctl_t ucode(input logic [STEP_W-1:0] s);
    ctl_t c;
    c = '0;
    unique case (s)
      S_CLR: begin
        c.mem_wr = 1'b1; c.wr_zero = 1'b1;
        c.cond = C_CLR_DONE; c.target = S_IDLE; c.stay = 1'b1;
      end
      S_IDLE: begin
        c.in_ready = 1'b1;
        c.cond = C_ACCEPT; c.target = S_LOAD; c.stay = 1'b1;
      end
      S_LOAD: begin
        c.pos_op = P_START; c.sum_clr = 1'b1;
        c.cond = C_QUERY; c.target = S_QCLAMP;
      end
      S_A1RD: begin
        c.mem_rd = 1'b1; c.cond = C_WALK_DONE; c.target = S_A2INIT;
      end
      S_A1WR: begin
        c.mem_wr = 1'b1; c.pos_op = P_UP; c.cond = C_ALWAYS; c.target = S_A1RD;
      end
      S_A2INIT: begin
        c.pos_op = P_END1; c.neg_delta = 1'b1; c.cond = C_NEVER;
      end
      S_A2RD: begin
        c.mem_rd = 1'b1; c.cond = C_WALK_DONE; c.target = S_IDLE;
      end
      S_A2WR: begin
        c.mem_wr = 1'b1; c.pos_op = P_UP; c.cond = C_ALWAYS; c.target = S_A2RD;
      end
      S_QCLAMP: begin
        c.pos_op = P_CLAMP; c.cond = C_NEVER;
      end
      S_QRD: begin
        c.mem_rd = 1'b1; c.cond = C_POS_ZERO; c.target = S_QOUT;
      end
      S_QACC: begin
        c.sum_acc = 1'b1; c.pos_op = P_DOWN; c.cond = C_ALWAYS; c.target = S_QRD;
      end
      S_QOUT: begin
        c.out_set = 1'b1; c.cond = C_OUT_FREE; c.target = S_IDLE; c.stay = 1'b1;
      end
      default: begin
        c.cond = C_ALWAYS; c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/frapq_if.sv @@
`default_nettype none
interface frapq_cmd_if import frapq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] end_pos;
  logic [VAL_W-1:0] amount;

  modport source (output valid, op, start_pos, end_pos, amount, input ready);
  modport sink (input valid, op, start_pos, end_pos, amount, output ready);
endinterface

interface frapq_rsp_if import frapq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] point_value;

  modport source (output valid, point_value, input ready);
  modport sink (input valid, point_value, output ready);
endinterface
`default_nettype wire

@@ rtl/fenwick_range_add_point_query.sv @@
// Fenwick tree over difference values: a range add of amount over
// [start_pos, end_pos] and a point query that returns the running value at one
// position, modulo 2^64. Items are taken one at a time by a small microcoded
// sequencer over a single-port tree store with a registered read. Every tree
// cell visited takes a read step, then a write or accumulate step. An upward
// walk and a downward walk each visit at most floor(log2(count)) + 1 cells. A
// query's result is held on rsp until rsp.ready takes it. After reset the
// store is zeroed by a pass over all MAX_POSITIONS cells, during which no item
// is accepted. Configuration writes are taken at any time; make them only
// while no item is in progress.
`default_nettype none
`include "fenwick_range_add_point_query_assert.svh"
module fenwick_range_add_point_query import frapq_pkg::*; #(
  parameter int MAX_POSITIONS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [POS_W-1:0] cfg_wdata,
  frapq_cmd_if.sink             cmd,
  frapq_rsp_if.source           rsp
);

  localparam int AW = $clog2(MAX_POSITIONS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POSITIONS - 1);
  localparam logic [WALK_W-1:0] MAX_CLAMP =
    WALK_W'((MAX_POSITIONS > 4095) ? 4095 : MAX_POSITIONS);

  logic [POS_W-1:0]  positions_in_use;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [AW-1:0]     clr_addr;
  logic              op;
  logic [POS_W-1:0]  start_pos;
  logic [POS_W-1:0]  end_pos;
  logic [VAL_W-1:0]  delta;
  logic [WALK_W-1:0] pos;
  logic [VAL_W-1:0]  sum;
  logic [VAL_W-1:0]  rd_data;
  logic              out_valid;
  logic [VAL_W-1:0]  out_data;

  logic [VAL_W-1:0]  mem [MAX_POSITIONS];

  ctl_t              ctl;
  logic [WALK_W-1:0] n;
  logic [WALK_W-1:0] low_bit;
  logic [WALK_W-1:0] pos_m1;
  logic [AW+WALK_W-1:0] pos_ext;
  logic [AW-1:0]     mem_addr;
  logic [VAL_W-1:0]  wr_data;
  logic              accept;
  logic              out_free;
  logic              cond_true;

  assign ctl      = ucode(step);
  assign n        = (32'(positions_in_use) > 32'(MAX_POSITIONS)) ? MAX_CLAMP
                                                                 : {1'b0, positions_in_use};
  assign low_bit  = pos & (~pos + WALK_W'(1));
  assign pos_m1   = pos - WALK_W'(1);
  assign pos_ext  = {{AW{1'b0}}, pos_m1};
  assign mem_addr = ctl.wr_zero ? clr_addr : pos_ext[AW-1:0];
  assign wr_data  = ctl.wr_zero ? '0 : rd_data + delta;
  assign accept   = cmd.valid && cmd.ready;
  assign out_free = !out_valid || rsp.ready;

  assign cmd.ready       = ctl.in_ready;
  assign rsp.valid       = out_valid;
  assign rsp.point_value = out_data;

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:     cond_true = 1'b0;
      C_ALWAYS:    cond_true = 1'b1;
      C_ACCEPT:    cond_true = accept;
      C_CLR_DONE:  cond_true = (clr_addr == LAST_ADDR);
      C_QUERY:     cond_true = op;
      C_WALK_DONE: cond_true = (pos == '0) || (pos > n);
      C_POS_ZERO:  cond_true = (pos == '0);
      C_OUT_FREE:  cond_true = out_free;
      default:     cond_true = 1'b0;
    endcase
  end

  always_comb begin
    priority if (cond_true) begin
      step_next = ctl.target;
    end else if (ctl.stay) begin
      step_next = step;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step             <= S_CLR;
      clr_addr         <= '0;
      positions_in_use <= POS_W'(1024);
      out_valid        <= 1'b0;
    end else begin
      step <= step_next;
      if (step == S_CLR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_we) begin
        positions_in_use <= cfg_wdata;
      end
      if (ctl.out_set && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= cmd.op;
      start_pos <= cmd.start_pos;
      end_pos   <= cmd.end_pos;
      delta     <= cmd.amount;
    end else if (ctl.neg_delta) begin
      delta <= ~delta + VAL_W'(1);
    end
    unique case (ctl.pos_op)
      P_START: pos <= {1'b0, start_pos};
      P_END1:  pos <= {1'b0, end_pos} + WALK_W'(1);
      P_CLAMP: pos <= (pos > n) ? n : pos;
      P_UP:    pos <= pos + low_bit;
      P_DOWN:  pos <= pos - low_bit;
      default: pos <= pos;
    endcase
    if (ctl.sum_clr) begin
      sum <= '0;
    end else if (ctl.sum_acc) begin
      sum <= sum + rd_data;
    end
    if (ctl.out_set && out_free) begin
      out_data <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_wr) begin
      mem[mem_addr] <= wr_data;
    end
    if (ctl.mem_rd) begin
      rd_data <= mem[mem_addr];
    end
  end

  `FRAPQ_ASSERT_IMPL(a_walk_write_in_range, clk, rst, ctl.mem_wr && !ctl.wr_zero, (pos != '0) && (pos <= n), "tree write outside the active positions")
  `FRAPQ_ASSERT_NEXT(a_accept_to_load, clk, rst, accept, step == S_LOAD, "accepted item not dispatched")
  `FRAPQ_ASSERT_IMPL(a_result_from_emit, clk, rst, $rose(out_valid), $past(step) == S_QOUT, "result raised outside the emit step")
  `FRAPQ_ASSERT_IMPL(a_query_acc_in_range, clk, rst, step == S_QACC, (pos != '0) && (pos <= n), "query walk beyond the active positions")

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import frapq_pkg::*;

  localparam int MAXP = 1024;
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_ITEMS = 140;
  localparam int HOLD_DELAY = 300;
  localparam int HOLD_CYCLES = 500;

  typedef struct {
    logic             op;
    logic [POS_W-1:0] lo_pos;
    logic [POS_W-1:0] hi_pos;
    logic [VAL_W-1:0] amt;
    bit               typed;
    logic [VAL_W-1:0] want;
  } row_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [POS_W-1:0] cfg_wdata;

  frapq_cmd_if cmd_bus ();
  frapq_rsp_if rsp_bus ();

  fenwick_range_add_point_query #(.MAX_POSITIONS(MAXP)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_bus),
    .rsp       (rsp_bus)
  );

  logic [VAL_W-1:0] diff_tree [1:MAXP];
  logic [POS_W-1:0] span_cfg;
  logic [VAL_W-1:0] pending_values [$];
  row_t             directed_rows [$];
  int               value_errors;
  int               burst_left;
  bit               hold_arm;
  logic             long_hold;
  int               stall_tick;
  int               stall_mode;
  logic [15:0]      stall_pat;
  logic             ready_next;
  logic [VAL_W-1:0] want_value;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned eff_span();
    return (span_cfg > MAXP) ? MAXP : int'(span_cfg);
  endfunction

  function automatic void climb(input int unsigned p, input logic [VAL_W-1:0] d);
    int unsigned n;
    n = eff_span();
    if (p == 0) return;
    while (p <= n) begin
      diff_tree[p] = diff_tree[p] + d;
      p = p + (p & (~p + 1));
    end
  endfunction

  function automatic logic [VAL_W-1:0] point_sum(input int unsigned p);
    int unsigned n;
    logic [VAL_W-1:0] acc;
    n = eff_span();
    acc = '0;
    if (p > n) p = n;
    while (p >= 1) begin
      acc = acc + diff_tree[p];
      p = p - (p & (~p + 1));
    end
    return acc;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int unsigned n;
    n = eff_span();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return POS_W'($urandom_range(0, 2047));
      2: return POS_W'(n);
      3: return POS_W'(n + 1);
      default: return POS_W'($urandom_range(1, (n == 0) ? 1 : n));
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_amount();
    int v;
    case ($urandom_range(0, 6))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '1;
      3: return '0;
      4: begin
        v = int'($urandom_range(0, 200)) - 100;
        return VAL_W'(longint'(v));
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void add_row(input logic op, input logic [POS_W-1:0] lo,
                                  input logic [POS_W-1:0] hi, input logic [VAL_W-1:0] amt,
                                  input bit typed, input logic [VAL_W-1:0] want);
    row_t r;
    r.op = op;
    r.lo_pos = lo;
    r.hi_pos = hi;
    r.amt = amt;
    r.typed = typed;
    r.want = want;
    directed_rows = {directed_rows, r};
  endfunction

  task automatic send_item(input logic op, input logic [POS_W-1:0] lo,
                           input logic [POS_W-1:0] hi, input logic [VAL_W-1:0] amt,
                           input bit typed, input logic [VAL_W-1:0] want);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.op <= op;
    cmd_bus.start_pos <= lo;
    cmd_bus.end_pos <= hi;
    cmd_bus.amount <= amt;
    cmd_bus.valid <= 1'b1;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    if (op == OP_QUERY) begin
      pending_values = {pending_values, (typed ? want : point_sum(lo))};
    end else begin
      climb(lo, amt);
      climb(int'(hi) + 1, ~amt + 1);
    end
  endtask

  task automatic send_random();
    logic op;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    logic [POS_W-1:0] t;
    op = logic'($urandom_range(0, 1));
    lo = pick_pos();
    hi = pick_pos();
    if (op == OP_ADD && hi < lo && $urandom_range(0, 3) != 0) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    send_item(op, lo, hi, pick_amount(), 1'b0, '0);
  endtask

  task automatic idle_then_config(input logic [POS_W-1:0] v);
    while (pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    span_cfg = v;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      stall_tick <= 0;
      stall_mode <= 0;
      stall_pat <= 16'b1011_0011_1000_1111;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_values.size() == 0) begin
          value_errors++;
          if (value_errors <= 10)
            $display("unexpected point_value %h", rsp_bus.point_value);
        end else begin
          want_value = pending_values.pop_front();
          if (rsp_bus.point_value !== want_value) begin
            value_errors++;
            if (value_errors <= 10)
              $display("point_value mismatch: expected %h actual %h", want_value,
                       rsp_bus.point_value);
          end
        end
      end
      stall_tick <= stall_tick + 1;
      if (stall_tick % 48 == 47) begin
        stall_mode <= $urandom_range(0, 3);
        stall_pat <= 16'($urandom);
      end else begin
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
      end
      case (stall_mode)
        0: ready_next = 1'b1;
        1: ready_next = logic'($urandom_range(0, 1));
        2: ready_next = stall_pat[0];
        default: ready_next = ($urandom_range(0, 3) == 0);
      endcase
      rsp_bus.ready <= long_hold ? 1'b0 : ready_next;
    end
  end

  initial begin
    long_hold = 1'b0;
    wait (hold_arm);
    repeat (HOLD_DELAY) @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [POS_W-1:0] phase_cfg [$];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.op = OP_ADD;
    cmd_bus.start_pos = '0;
    cmd_bus.end_pos = '0;
    cmd_bus.amount = '0;
    value_errors = 0;
    burst_left = 0;
    hold_arm = 1'b0;
    span_cfg = 11'd1024;
    for (int i = 1; i <= MAXP; i++) diff_tree[i] = '0;

    add_row(OP_QUERY, 11'd1, 11'd0, '0, 1'b1, 64'd0);
    add_row(OP_QUERY, 11'd1024, 11'd0, '0, 1'b1, 64'd0);
    add_row(OP_QUERY, 11'd0, 11'd0, '0, 1'b1, 64'd0);
    add_row(OP_QUERY, 11'd2047, 11'd2047, '0, 1'b1, 64'd0);
    add_row(OP_ADD, 11'd1, 11'd1024, 64'd5, 1'b0, '0);
    add_row(OP_QUERY, 11'd1, 11'd0, '0, 1'b1, 64'd5);
    add_row(OP_QUERY, 11'd1024, 11'd0, '0, 1'b1, 64'd5);
    add_row(OP_QUERY, 11'd2047, 11'd0, '0, 1'b1, 64'd5);
    add_row(OP_ADD, 11'd1, 11'd1, 64'h8000_0000_0000_0000, 1'b0, '0);
    add_row(OP_QUERY, 11'd1, 11'd0, '0, 1'b1, 64'h8000_0000_0000_0005);
    add_row(OP_QUERY, 11'd2, 11'd0, '0, 1'b1, 64'd5);
    add_row(OP_ADD, 11'd0, 11'd9, 64'd7, 1'b0, '0);
    add_row(OP_QUERY, 11'd10, 11'd0, '0, 1'b0, '0);
    add_row(OP_QUERY, 11'd9, 11'd0, '0, 1'b0, '0);
    add_row(OP_ADD, 11'd20, 11'd10, 64'd3, 1'b0, '0);
    add_row(OP_QUERY, 11'd15, 11'd0, '0, 1'b0, '0);
    add_row(OP_ADD, 11'd2047, 11'd2047, 64'h7fff_ffff_ffff_ffff, 1'b0, '0);
    add_row(OP_QUERY, 11'd2047, 11'd0, '0, 1'b0, '0);
    add_row(OP_ADD, 11'd1, 11'd2046, 64'h7fff_ffff_ffff_ffff, 1'b0, '0);
    add_row(OP_QUERY, 11'd512, 11'd0, '0, 1'b0, '0);
    add_row(OP_ADD, 11'd1024, 11'd1024, '1, 1'b0, '0);
    add_row(OP_QUERY, 11'd1024, 11'd0, '0, 1'b0, '0);
    add_row(OP_QUERY, 11'd0, 11'd2047, '1, 1'b1, 64'd0);
    add_row(OP_ADD, 11'd0, 11'd0, 64'd0, 1'b0, '0);
    add_row(OP_QUERY, 11'd1, 11'd0, '0, 1'b0, '0);

    phase_cfg = '{11'd1, 11'd2047, 11'd0, 11'd1024, 11'd2, 11'd37,
                  POS_W'($urandom_range(1, 1024)), 11'd1023,
                  POS_W'($urandom_range(1, 1024)), 11'd1024};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].lo_pos, directed_rows[i].hi_pos,
                directed_rows[i].amt, directed_rows[i].typed, directed_rows[i].want);
    cmd_bus.valid <= 1'b0;

    foreach (phase_cfg[i]) begin
      idle_then_config(phase_cfg[i]);
      if (phase_cfg[i] == 11'd1024) hold_arm = 1'b1;
      repeat (PHASE_ITEMS) send_random();
      cmd_bus.valid <= 1'b0;
    end

    while (pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (value_errors == 0 && pending_values.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ fenwick_range_add_point_query.f @@
+incdir+rtl
rtl/frapq_pkg.sv
rtl/frapq_if.sv
rtl/fenwick_range_add_point_query.sv
tb/sv/tb_top.sv
